>>> hw/rtl/cpo_pkg.sv
// Package with the shared constants and control structs of the polygon overlap test.
package cpo_pkg;

  localparam int unsigned MAX_VERTICES = 16;
  localparam int unsigned IDX_W        = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned WORD_W       = 2 * COORD_W;
  localparam int unsigned AXIS_W       = COORD_W + 1;
  localparam int unsigned PROD_W       = COORD_W + AXIS_W;
  localparam int unsigned DOT_W        = PROD_W + 1;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_VERTICES);

  localparam logic POLY_FIRST  = 1'b0;
  localparam logic POLY_SECOND = 1'b1;

  // Start request from the loader to the test engine.
  typedef struct packed {
    logic             start;
    logic             bad;
    logic [CNT_W-1:0] count_a;
    logic [CNT_W-1:0] count_b;
  } start_req_t;

  // Finished result held by the engine until the output register takes it.
  typedef struct packed {
    logic valid;
    logic collides;
    logic bad_input;
  } result_t;

endpackage

>>> hw/rtl/cpo_if.sv
// Handshake interfaces for the vertex input channel and the result channel.
interface cpo_in_if;
  logic                               valid;
  logic                               ready;
  logic                               polygon_id;
  logic signed [cpo_pkg::COORD_W-1:0] vertex_x;
  logic signed [cpo_pkg::COORD_W-1:0] vertex_y;
  logic                               end_of_pair;

  modport source (output valid, polygon_id, vertex_x, vertex_y, end_of_pair, input ready);
  modport sink   (input valid, polygon_id, vertex_x, vertex_y, end_of_pair, output ready);
endinterface

interface cpo_out_if;
  logic valid;
  logic ready;
  logic collides;
  logic bad_input;

  modport source (output valid, collides, bad_input, input ready);
  modport sink   (input valid, collides, bad_input, output ready);
endinterface

>>> hw/rtl/cpo_vertex_ram.sv
// Vertex store: one write port, one read port with registered read data.
module cpo_vertex_ram (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [cpo_pkg::IDX_W-1:0]         waddr_i,
  input  logic [cpo_pkg::WORD_W-1:0]        wdata_i,
  input  logic [cpo_pkg::IDX_W-1:0]         raddr_i,
  output logic [cpo_pkg::WORD_W-1:0]        rdata_o
);

  logic [cpo_pkg::WORD_W-1:0] mem_q [cpo_pkg::MAX_VERTICES];
  logic [cpo_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/cpo_sat_engine.sv
// Separating-axis sequencer: reads edges, projects both stores, compares extremes.
module cpo_sat_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cpo_pkg::start_req_t          req_i,
  input  logic                         ack_i,
  output cpo_pkg::result_t             res_o,
  output logic [cpo_pkg::IDX_W-1:0]    raddr_a_o,
  output logic [cpo_pkg::IDX_W-1:0]    raddr_b_o,
  input  logic [cpo_pkg::WORD_W-1:0]   rdata_a_i,
  input  logic [cpo_pkg::WORD_W-1:0]   rdata_b_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EDGE_RD0, ST_EDGE_RD1, ST_EDGE_AX, ST_PROJ, ST_DRAIN, ST_CMP, ST_DONE
  } state_e;

  localparam int unsigned CW = cpo_pkg::CNT_W;
  localparam int unsigned IW = cpo_pkg::IDX_W;
  localparam int unsigned XW = cpo_pkg::COORD_W;

  state_e                            state_q;
  logic                              side_q;
  logic [CW-1:0]                     edge_q;
  logic [CW-1:0]                     k_q;
  logic [CW-1:0]                     na_q;
  logic [CW-1:0]                     nb_q;
  logic [cpo_pkg::WORD_W-1:0]        vi_q;
  logic signed [cpo_pkg::AXIS_W-1:0] ax_q;
  logic signed [cpo_pkg::AXIS_W-1:0] ay_q;
  logic                              v1a_q, v1b_q, v2a_q, v2b_q;
  logic                              first_a_q, first_b_q;
  logic signed [cpo_pkg::PROD_W-1:0] pax_q, pay_q, pbx_q, pby_q;
  logic signed [cpo_pkg::DOT_W-1:0]  alo_q, ahi_q, blo_q, bhi_q;
  logic                              res_coll_q, res_bad_q;

  logic [CW-1:0]                     ne;
  logic [CW-1:0]                     kmax;
  logic [CW-1:0]                     edge_nxt;
  logic [IW-1:0]                     j_idx;
  logic [cpo_pkg::WORD_W-1:0]        edge_rdata;
  logic signed [XW-1:0]              xi, yi, xj, yj;
  logic signed [cpo_pkg::PROD_W-1:0] pax_d, pay_d, pbx_d, pby_d;
  logic signed [cpo_pkg::DOT_W-1:0]  dot_a, dot_b;
  logic                              sep;

  assign ne       = side_q ? nb_q : na_q;
  assign kmax     = (na_q > nb_q) ? na_q : nb_q;
  assign edge_nxt = edge_q + CW'(1);
  assign j_idx    = (edge_nxt == ne) ? '0 : edge_nxt[IW-1:0];

  assign edge_rdata = side_q ? rdata_b_i : rdata_a_i;
  assign xi = $signed(vi_q[XW-1:0]);
  assign yi = $signed(vi_q[2*XW-1:XW]);
  assign xj = $signed(edge_rdata[XW-1:0]);
  assign yj = $signed(edge_rdata[2*XW-1:XW]);

  assign pax_d = $signed(rdata_a_i[XW-1:0])      * ax_q;
  assign pay_d = $signed(rdata_a_i[2*XW-1:XW])   * ay_q;
  assign pbx_d = $signed(rdata_b_i[XW-1:0])      * ax_q;
  assign pby_d = $signed(rdata_b_i[2*XW-1:XW])   * ay_q;

  assign dot_a = cpo_pkg::DOT_W'(pax_q) + cpo_pkg::DOT_W'(pay_q);
  assign dot_b = cpo_pkg::DOT_W'(pbx_q) + cpo_pkg::DOT_W'(pby_q);

  assign sep = (ahi_q < blo_q) || (bhi_q < alo_q);

  // Edge reads use the store of the polygon whose edges are being walked.
  always_comb begin
    raddr_a_o = k_q[IW-1:0];
    raddr_b_o = k_q[IW-1:0];
    case (state_q)
      ST_EDGE_RD0: begin
        if (side_q) raddr_b_o = edge_q[IW-1:0];
        else        raddr_a_o = edge_q[IW-1:0];
      end
      ST_EDGE_RD1: begin
        if (side_q) raddr_b_o = j_idx;
        else        raddr_a_o = j_idx;
      end
      default: ;
    endcase
  end

  assign res_o = '{valid: (state_q == ST_DONE), collides: res_coll_q, bad_input: res_bad_q};

  // Products are payload and are registered every cycle.
  always_ff @(posedge clk_i) begin
    pax_q <= pax_d;
    pay_q <= pay_d;
    pbx_q <= pbx_d;
    pby_q <= pby_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      side_q     <= 1'b0;
      edge_q     <= '0;
      k_q        <= '0;
      na_q       <= '0;
      nb_q       <= '0;
      vi_q       <= '0;
      ax_q       <= '0;
      ay_q       <= '0;
      v1a_q      <= 1'b0;
      v1b_q      <= 1'b0;
      v2a_q      <= 1'b0;
      v2b_q      <= 1'b0;
      first_a_q  <= 1'b0;
      first_b_q  <= 1'b0;
      alo_q      <= '0;
      ahi_q      <= '0;
      blo_q      <= '0;
      bhi_q      <= '0;
      res_coll_q <= 1'b0;
      res_bad_q  <= 1'b0;
    end else begin
      v1a_q <= 1'b0;
      v1b_q <= 1'b0;
      v2a_q <= v1a_q;
      v2b_q <= v1b_q;

      if (v2a_q) begin
        if (first_a_q || dot_a < alo_q) alo_q <= dot_a;
        if (first_a_q || dot_a > ahi_q) ahi_q <= dot_a;
        first_a_q <= 1'b0;
      end
      if (v2b_q) begin
        if (first_b_q || dot_b < blo_q) blo_q <= dot_b;
        if (first_b_q || dot_b > bhi_q) bhi_q <= dot_b;
        first_b_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (req_i.start) begin
            na_q   <= req_i.count_a;
            nb_q   <= req_i.count_b;
            side_q <= cpo_pkg::POLY_FIRST;
            edge_q <= '0;
            if (req_i.bad) begin
              res_coll_q <= 1'b0;
              res_bad_q  <= 1'b1;
              state_q    <= ST_DONE;
            end else begin
              res_bad_q <= 1'b0;
              state_q   <= ST_EDGE_RD0;
            end
          end
        end
        ST_EDGE_RD0: state_q <= ST_EDGE_RD1;
        ST_EDGE_RD1: begin
          vi_q    <= edge_rdata;
          state_q <= ST_EDGE_AX;
        end
        ST_EDGE_AX: begin
          // Axis is the perpendicular (-(yj - yi), xj - xi).
          ax_q      <= cpo_pkg::AXIS_W'(yi) - cpo_pkg::AXIS_W'(yj);
          ay_q      <= cpo_pkg::AXIS_W'(xj) - cpo_pkg::AXIS_W'(xi);
          k_q       <= '0;
          first_a_q <= 1'b1;
          first_b_q <= 1'b1;
          state_q   <= ST_PROJ;
        end
        ST_PROJ: begin
          v1a_q <= (k_q < na_q);
          v1b_q <= (k_q < nb_q);
          k_q   <= k_q + CW'(1);
          if (k_q == kmax - CW'(1)) state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!v1a_q && !v1b_q && !v2a_q && !v2b_q) state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (sep) begin
            res_coll_q <= 1'b0;
            state_q    <= ST_DONE;
          end else if (edge_nxt == ne) begin
            if (side_q == cpo_pkg::POLY_SECOND) begin
              res_coll_q <= 1'b1;
              state_q    <= ST_DONE;
            end else begin
              side_q  <= cpo_pkg::POLY_SECOND;
              edge_q  <= '0;
              state_q <= ST_EDGE_RD0;
            end
          end else begin
            edge_q  <= edge_nxt;
            state_q <= ST_EDGE_RD0;
          end
        end
        ST_DONE: begin
          if (ack_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/convex_polygon_overlap_test.sv
// Top level of the 2-D convex polygon overlap test (separating axis).
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   polygon_id, vertex_x, vertex_y, end_of_pair
//   out_o    out  valid/ready   collides, bad_input
//
// A vertex item is written to its polygon's store; an item for a full store is
// dropped and marks the pair bad. The item with end_of_pair starts the test;
// the input then stays not ready until the result enters the output register.
// The test walks the edges of both polygons until an axis separates them, using
// the one read port of each vertex store feeding a single projection unit.
// Reset empties both stores by clearing their counts; no clearing pass is needed.
module convex_polygon_overlap_test (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpo_in_if.sink    in_i,
  cpo_out_if.source out_o
);

  localparam int unsigned CW = cpo_pkg::CNT_W;
  localparam int unsigned IW = cpo_pkg::IDX_W;

  logic [CW-1:0] cnt_a_q, cnt_a_d;
  logic [CW-1:0] cnt_b_q, cnt_b_d;
  logic          ovf_q, ovf_d;
  logic          busy_q, busy_d;
  logic          out_valid_q, out_valid_d;
  logic          out_coll_q, out_bad_q;

  logic                        accept;
  logic                        we_a, we_b;
  logic [cpo_pkg::WORD_W-1:0]  wdata;
  logic [IW-1:0]               raddr_a, raddr_b;
  logic [cpo_pkg::WORD_W-1:0]  rdata_a, rdata_b;
  cpo_pkg::start_req_t         req;
  cpo_pkg::result_t            res;
  logic                        take;

  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && in_i.ready;
  assign wdata      = {in_i.vertex_y, in_i.vertex_x};

  assign we_a = accept && (in_i.polygon_id == cpo_pkg::POLY_FIRST)
                && (cnt_a_q != cpo_pkg::CNT_FULL);
  assign we_b = accept && (in_i.polygon_id == cpo_pkg::POLY_SECOND)
                && (cnt_b_q != cpo_pkg::CNT_FULL);

  assign take = res.valid && (!out_valid_q || out_o.ready);

  always_comb begin
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    ovf_d   = ovf_q;
    if (we_a) cnt_a_d = cnt_a_q + CW'(1);
    if (we_b) cnt_b_d = cnt_b_q + CW'(1);
    if (accept && !we_a && !we_b) ovf_d = 1'b1;

    req.start   = accept && in_i.end_of_pair;
    req.count_a = cnt_a_d;
    req.count_b = cnt_b_d;
    req.bad     = ovf_d || (cnt_a_d == '0) || (cnt_b_d == '0);

    busy_d = busy_q;
    if (req.start) begin
      // The engine holds its own copies of the counts from here on.
      cnt_a_d = '0;
      cnt_b_d = '0;
      ovf_d   = 1'b0;
      busy_d  = 1'b1;
    end
    if (take) busy_d = 1'b0;

    out_valid_d = out_valid_q && !out_o.ready;
    if (take) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ovf_q       <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      ovf_q       <= ovf_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_coll_q <= res.collides;
      out_bad_q  <= res.bad_input;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.collides  = out_coll_q;
  assign out_o.bad_input = out_bad_q;

  cpo_vertex_ram u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[IW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  cpo_vertex_ram u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[IW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  cpo_sat_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .ack_i     (take),
    .res_o     (res),
    .raddr_a_o (raddr_a),
    .raddr_b_o (raddr_b),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b)
  );

endmodule

>>> hw/rtl/cpo_checker.sv
// Port-level checks of the polygon overlap test and their binding to the top level.
module cpo_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_end_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_collides_i,
  input logic out_bad_i
);

  // A result that waits must not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_collides_i)
                                    && $stable(out_bad_i))
    else $error("result changed while stalled");

  // A rejected pair never reports a collision.
  a_bad_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_bad_i |-> !out_collides_i)
    else $error("collision reported on bad input");

  // An accepted end of a pair closes the input.
  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_end_i |=> !in_ready_i)
    else $error("input ready right after end of pair");

  // A new result only appears after a test that held the input closed.
  a_result_after_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result without a preceding test");

endmodule

bind convex_polygon_overlap_test cpo_checker u_cpo_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_end_i       (in_i.end_of_pair),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_collides_i (out_o.collides),
  .out_bad_i      (out_o.bad_input)
);
